// File: rtl/vper_pkg.sv
`timescale 1ns / 1ps
package vper_pkg;

	// ring geometry
	localparam int BUF_BYTES = 1024;
	localparam int AW = $clog2(BUF_BYTES);
	localparam int NW = (AW + 1 > 11) ? AW + 1 : 11;
	localparam int CAP = BUF_BYTES - 1;

	typedef enum logic [1:0] {
		CMD_PUSH_START = 2'd0,
		CMD_PUSH_DATA  = 2'd1,
		CMD_POP        = 2'd2,
		CMD_READ       = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_NO_ROOM   = 3'd1,
		STS_EMPTY     = 3'd2,
		STS_TOO_LARGE = 3'd3,
		STS_BAD_SEQ   = 3'd4,
		STS_BAD_INDEX = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DROP,
		S_WP0,
		S_WP1,
		S_PCLOSE,
		S_RF_A,
		S_RF_B,
		S_RF_C,
		S_RD,
		S_FIN
	} state_t;

	// position plus offset, wrapped at the ring size (offset below ring size)
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] pos,
			input logic [NW-1:0] n);
		logic [NW:0] s;
		s = (NW+1)'(pos) + (NW+1)'(n);
		if (s >= (NW+1)'(BUF_BYTES))
			s = s - (NW+1)'(BUF_BYTES);
		return s[AW-1:0];
	endfunction

	// low ten bits of a counter
	function automatic logic [9:0] low10(input logic [AW-1:0] x);
		logic [31:0] t;
		t = 32'(x);
		return t[9:0];
	endfunction

endpackage

// File: rtl/vper_if.sv
`timescale 1ns / 1ps
interface vper_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [9:0] entry_length;
	logic [7:0] data_byte;
	logic [9:0] byte_index;
	modport source (output valid, cmd, entry_length, data_byte, byte_index, input ready);
	modport sink (input valid, cmd, entry_length, data_byte, byte_index, output ready);
endinterface

interface vper_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] read_byte;
	logic [9:0] front_length;
	logic [9:0] record_total;
	logic [9:0] used_bytes;
	logic [9:0] dropped_entries;
	modport source (output valid, status, read_byte, front_length, record_total, used_bytes,
		dropped_entries, input ready);
	modport sink (input valid, status, read_byte, front_length, record_total, used_bytes,
		dropped_entries, output ready);
endinterface

interface vper_cfg_if;
	logic valid;
	logic ready;
	logic overwrite_mode;
	modport source (output valid, overwrite_mode, input ready);
	modport sink (input valid, overwrite_mode, output ready);
endinterface

// File: rtl/vper_ram.sv
`timescale 1ns / 1ps
module vper_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: rtl/varint_prefixed_entry_ring.sv
`timescale 1ns / 1ps
// Byte ring of records, each an LEB128 length prefix (one byte below 128, else two) and its
// data, kept in one single-port RAM. A word refused with an error status goes straight to its
// result. A data byte is written behind the open record; when it completes the record, the front
// prefix is re-read. An accepted push start drops the oldest records until the new one fits
// (overwrite mode), re-reading the front prefix after each, writes the one or two prefix bytes
// and, for a zero-length record, closes it and re-reads the front prefix. Pop moves the head
// past the front record and re-reads the front prefix unless the ring is left empty; a read
// fetches one data byte. The single RAM port serves prefix writes, data writes, prefix reads
// and data reads in turn. A result may wait on the output while the next word is taken; the
// result after it waits until the output is free. overwrite_mode is written on its own channel;
// the user must write it only while the block is idle, which the block itself does not enforce.
module varint_prefixed_entry_ring import vper_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	vper_in_if.sink    in_ch,
	vper_out_if.source out_ch,
	vper_cfg_if.sink   cfg_ch
);
	state_t          state_q, state_d;
	logic [AW-1:0]   head_q, head_d, tail_q, tail_d, pend_q, pend_d;
	logic [AW-1:0]   cnt_q, cnt_d, drop_q, drop_d;
	logic [9:0]      left_q, left_d, len_q, len_d, flen_q, flen_d;
	logic            open_q, open_d, plen2_q, plen2_d, ret_drop_q, ret_drop_d;
	logic [6:0]      b0_q, b0_d;
	status_t         sts_q, sts_d;
	logic [7:0]      rbyte_q, rbyte_d;
	logic            ow_q;
	logic            ovalid_q;
	logic            out_load;

	logic            mem_we;
	logic [AW-1:0]   mem_addr;
	logic [7:0]      mem_wdata, mem_rdata;

	logic            in_acc;
	logic [AW:0]     used_x;
	logic [NW-1:0]   used_w, need_w, need_q_w, front_span;

	vper_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// config register
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ow_q <= 1'b0;
		else if (cfg_ch.valid)
			ow_q <= cfg_ch.overwrite_mode;
	end

	// occupancy and sizes
	always_comb begin
		if (tail_q >= head_q)
			used_x = (AW+1)'(tail_q) - (AW+1)'(head_q);
		else
			used_x = (AW+1)'(tail_q) + (AW+1)'(BUF_BYTES) - (AW+1)'(head_q);
		used_w     = NW'(used_x);
		need_w     = NW'(in_ch.entry_length) + ((in_ch.entry_length < 10'd128) ? NW'(1) : NW'(2));
		need_q_w   = NW'(len_q) + (plen2_q ? NW'(2) : NW'(1));
		front_span = NW'(flen_q) + ((flen_q < 10'd128) ? NW'(1) : NW'(2));
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == S_FIN) && (!ovalid_q || out_ch.ready);

	// next state, datapath and memory port
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		pend_d     = pend_q;
		cnt_d      = cnt_q;
		drop_d     = drop_q;
		left_d     = left_q;
		len_d      = len_q;
		flen_d     = flen_q;
		open_d     = open_q;
		plen2_d    = plen2_q;
		ret_drop_d = ret_drop_q;
		b0_d       = b0_q;
		sts_d      = sts_q;
		rbyte_d    = rbyte_q;
		mem_we     = 1'b0;
		mem_addr   = head_q;
		mem_wdata  = 8'd0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					sts_d      = STS_OK;
					rbyte_d    = 8'd0;
					drop_d     = '0;
					ret_drop_d = 1'b0;
					len_d      = in_ch.entry_length;
					plen2_d    = (in_ch.entry_length >= 10'd128);
					state_d    = S_FIN;
					unique case (cmd_t'(in_ch.cmd))
						CMD_PUSH_START: begin
							if (open_q)
								sts_d = STS_BAD_SEQ;
							else if (need_w > NW'(CAP))
								sts_d = STS_TOO_LARGE;
							else if (need_w > NW'(CAP) - used_w && !ow_q)
								sts_d = STS_NO_ROOM;
							else
								state_d = S_DROP;
						end
						CMD_PUSH_DATA: begin
							if (!open_q) begin
								sts_d = STS_BAD_SEQ;
							end else begin
								mem_we    = 1'b1;
								mem_addr  = pend_q;
								mem_wdata = in_ch.data_byte;
								pend_d    = wrap_add(pend_q, NW'(1));
								left_d    = left_q - 10'd1;
								if (left_q == 10'd1) begin
									open_d  = 1'b0;
									tail_d  = wrap_add(pend_q, NW'(1));
									cnt_d   = cnt_q + AW'(1);
									state_d = S_RF_A;
								end
							end
						end
						CMD_POP: begin
							if (cnt_q == '0) begin
								sts_d = STS_EMPTY;
							end else begin
								head_d  = wrap_add(head_q, front_span);
								cnt_d   = cnt_q - AW'(1);
								state_d = S_RF_A;
							end
						end
						CMD_READ: begin
							if (cnt_q == '0) begin
								sts_d = STS_EMPTY;
							end else if (in_ch.byte_index >= flen_q) begin
								sts_d = STS_BAD_INDEX;
							end else begin
								mem_addr = wrap_add(head_q, NW'(in_ch.byte_index) +
									((flen_q < 10'd128) ? NW'(1) : NW'(2)));
								state_d  = S_RD;
							end
						end
						default: state_d = S_FIN;
					endcase
				end
			end
			// drop oldest records until the new one fits
			S_DROP: begin
				if (need_q_w > NW'(CAP) - used_w && cnt_q != '0) begin
					head_d     = wrap_add(head_q, front_span);
					cnt_d      = cnt_q - AW'(1);
					drop_d     = drop_q + AW'(1);
					ret_drop_d = 1'b1;
					state_d    = S_RF_A;
				end else begin
					state_d = S_WP0;
				end
			end
			// prefix bytes behind the committed tail
			S_WP0: begin
				mem_we    = 1'b1;
				mem_addr  = tail_q;
				mem_wdata = plen2_q ? {1'b1, len_q[6:0]} : {1'b0, len_q[6:0]};
				pend_d    = wrap_add(tail_q, NW'(1));
				state_d   = plen2_q ? S_WP1 : S_PCLOSE;
			end
			S_WP1: begin
				mem_we    = 1'b1;
				mem_addr  = pend_q;
				mem_wdata = {5'd0, len_q[9:7]};
				pend_d    = wrap_add(pend_q, NW'(1));
				state_d   = S_PCLOSE;
			end
			S_PCLOSE: begin
				ret_drop_d = 1'b0;
				if (len_q == 10'd0) begin
					tail_d  = pend_q;
					cnt_d   = cnt_q + AW'(1);
					state_d = S_RF_A;
				end else begin
					open_d  = 1'b1;
					left_d  = len_q;
					state_d = S_FIN;
				end
			end
			// re-read the front prefix
			S_RF_A: begin
				if (cnt_q == '0) begin
					flen_d  = 10'd0;
					state_d = ret_drop_q ? S_DROP : S_FIN;
				end else begin
					mem_addr = head_q;
					state_d  = S_RF_B;
				end
			end
			S_RF_B: begin
				b0_d = mem_rdata[6:0];
				if (mem_rdata[7]) begin
					mem_addr = wrap_add(head_q, NW'(1));
					state_d  = S_RF_C;
				end else begin
					flen_d  = {3'd0, mem_rdata[6:0]};
					state_d = ret_drop_q ? S_DROP : S_FIN;
				end
			end
			S_RF_C: begin
				flen_d  = {mem_rdata[2:0], b0_q};
				state_d = ret_drop_q ? S_DROP : S_FIN;
			end
			S_RD: begin
				rbyte_d = mem_rdata;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			pend_q     <= '0;
			cnt_q      <= '0;
			left_q     <= '0;
			open_q     <= 1'b0;
			flen_q     <= '0;
			ret_drop_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			pend_q     <= pend_d;
			cnt_q      <= cnt_d;
			left_q     <= left_d;
			open_q     <= open_d;
			flen_q     <= flen_d;
			ret_drop_q <= ret_drop_d;
			if (out_load)
				ovalid_q <= 1'b1;
			else if (out_ch.ready)
				ovalid_q <= 1'b0;
		end
	end

	// per-word working registers
	always_ff @(posedge clk) begin
		drop_q  <= drop_d;
		len_q   <= len_d;
		plen2_q <= plen2_d;
		b0_q    <= b0_d;
		sts_q   <= sts_d;
		rbyte_q <= rbyte_d;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.status          <= sts_q;
			out_ch.read_byte       <= rbyte_q;
			out_ch.front_length    <= flen_q;
			out_ch.record_total    <= low10(cnt_q);
			out_ch.used_bytes      <= low10(used_x[AW-1:0]);
			out_ch.dropped_entries <= low10(drop_q);
		end
	end
	assign out_ch.valid = ovalid_q;

	// checks
	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && cnt_q == '0) |-> flen_q == 10'd0)
		else $error("front length nonzero with no records");
	a_open_left: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> left_q != 10'd0)
		else $error("open push with nothing left");
	a_used_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_w <= NW'(CAP))
		else $error("ring over capacity");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(NW+1)'(head_q) < (NW+1)'(BUF_BYTES) && (NW+1)'(tail_q) < (NW+1)'(BUF_BYTES))
		else $error("pointer beyond ring");
endmodule

// File: tb/sv/varint_ring_checker.sv
`timescale 1ns / 1ps
module varint_ring_checker import vper_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	vper_in_if   in_mon,
	vper_out_if  out_mon,
	vper_cfg_if  cfg_mon,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		status_t    status;
		logic [7:0] read_byte;
		logic [9:0] front_length;
		logic [9:0] record_total;
		logic [9:0] used_bytes;
		logic [9:0] dropped_entries;
	} ring_result_t;

	// shadow copy of the ring
	logic [7:0] ring_mem [0:1023];
	logic [9:0] head_pos, tail_pos, wr_pos, bytes_left, rec_cnt;
	logic       push_busy, drop_mode;
	ring_result_t results_q [$];

	function automatic logic [9:0] used_now();
		return tail_pos - head_pos;
	endfunction

	// data length of the record at the head, prefix size through plen
	function automatic logic [9:0] head_len(output logic [1:0] plen);
		logic [7:0] b0;
		b0 = ring_mem[head_pos];
		if (b0[7]) begin
			plen = 2'd2;
			return {ring_mem[head_pos + 10'd1][2:0], b0[6:0]};
		end
		plen = 2'd1;
		return {3'd0, b0[6:0]};
	endfunction

	function automatic void drop_head();
		logic [1:0] pl;
		logic [9:0] dl;
		dl = head_len(pl);
		head_pos = head_pos + dl + 10'(pl);
		rec_cnt = rec_cnt - 10'd1;
	endfunction

	function automatic void store_byte(logic [7:0] v);
		ring_mem[wr_pos] = v;
		wr_pos = wr_pos + 10'd1;
	endfunction

	// work out the result of one accepted word
	function automatic ring_result_t ring_step(cmd_t c, logic [9:0] len, logic [7:0] db,
			logic [9:0] idx);
		ring_result_t r;
		int need;
		logic [1:0] pl;
		logic [9:0] dl;
		r = '0;
		r.status = STS_OK;
		case (c)
			CMD_PUSH_START: begin
				need = (len < 128 ? 2 : 3) - 1 + int'(len);
				if (push_busy)
					r.status = STS_BAD_SEQ;
				else if (need > CAP)
					r.status = STS_TOO_LARGE;
				else if (need > CAP - int'(used_now()) && !drop_mode)
					r.status = STS_NO_ROOM;
				else begin
					while (need > CAP - int'(used_now()) && rec_cnt > 0) begin
						drop_head();
						r.dropped_entries = r.dropped_entries + 10'd1;
					end
					wr_pos = tail_pos;
					if (len < 128)
						store_byte(len[7:0]);
					else begin
						store_byte({1'b1, len[6:0]});
						store_byte({5'd0, len[9:7]});
					end
					if (len == 0) begin
						tail_pos = wr_pos;
						rec_cnt = rec_cnt + 10'd1;
					end else begin
						bytes_left = len;
						push_busy = 1'b1;
					end
				end
			end
			CMD_PUSH_DATA: begin
				if (!push_busy)
					r.status = STS_BAD_SEQ;
				else begin
					store_byte(db);
					bytes_left = bytes_left - 10'd1;
					if (bytes_left == 0) begin
						push_busy = 1'b0;
						tail_pos = wr_pos;
						rec_cnt = rec_cnt + 10'd1;
					end
				end
			end
			CMD_POP: begin
				if (rec_cnt == 0)
					r.status = STS_EMPTY;
				else
					drop_head();
			end
			default: begin
				if (rec_cnt == 0)
					r.status = STS_EMPTY;
				else begin
					dl = head_len(pl);
					if (idx >= dl)
						r.status = STS_BAD_INDEX;
					else
						r.read_byte = ring_mem[head_pos + 10'(pl) + idx];
				end
			end
		endcase
		if (rec_cnt != 0)
			r.front_length = head_len(pl);
		r.record_total = rec_cnt;
		r.used_bytes = used_now();
		return r;
	endfunction

	task automatic compare_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ring_result_t exp_r;
		if (!arst_n) begin
			head_pos = '0;
			tail_pos = '0;
			wr_pos = '0;
			bytes_left = '0;
			rec_cnt = '0;
			push_busy = 1'b0;
			drop_mode = 1'b0;
			fail_count = 0;
			pending <= 0;
		end else begin
			// compare each result word with the oldest expectation
			if (out_mon.valid && out_mon.ready) begin
				if (results_q.size() == 0) begin
					$display("%0t: unexpected result word, status %0d", $time, out_mon.status);
					fail_count++;
				end else begin
					exp_r = results_q.pop_front();
					compare_field("status", exp_r.status, out_mon.status);
					compare_field("read_byte", exp_r.read_byte, out_mon.read_byte);
					compare_field("front_length", exp_r.front_length, out_mon.front_length);
					compare_field("record_total", exp_r.record_total, out_mon.record_total);
					compare_field("used_bytes", exp_r.used_bytes, out_mon.used_bytes);
					compare_field("dropped_entries", exp_r.dropped_entries,
						out_mon.dropped_entries);
				end
			end
			// predict each accepted command word
			if (in_mon.valid && in_mon.ready)
				results_q.push_back(ring_step(cmd_t'(in_mon.cmd), in_mon.entry_length,
					in_mon.data_byte, in_mon.byte_index));
			if (cfg_mon.valid && cfg_mon.ready)
				drop_mode = cfg_mon.overwrite_mode;
			pending <= results_q.size();
		end
	end

endmodule

// File: tb/sv/varint_prefixed_entry_ring_tb.sv
`timescale 1ns / 1ps
module varint_prefixed_entry_ring_tb import vper_pkg::*; ();

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count, pending;
	bit   idle_en = 1'b1;
	int   word_cnt = 0;
	int   big_left = 0;

	vper_in_if  in_if();
	vper_out_if out_if();
	vper_cfg_if cfg_if();

	varint_prefixed_entry_ring dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg_ch (cfg_if)
	);

	varint_ring_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_if),
		.out_mon    (out_if),
		.cfg_mon    (cfg_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// result side stalls at random
	always @(posedge clk) begin
		if (!arst_n)
			out_if.ready <= 1'b0;
		else
			out_if.ready <= !idle_en || ($urandom_range(99) >= 37);
	end

	// send one command word, idling at random before it
	task automatic send_word(cmd_t c, logic [9:0] len, logic [7:0] b, logic [9:0] idx);
		while (idle_en && $urandom_range(99) < 37) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.cmd <= c;
		in_if.entry_length <= len;
		in_if.data_byte <= b;
		in_if.byte_index <= idx;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		word_cnt++;
	endtask

	// push start followed by n data bytes
	task automatic push_record(logic [9:0] len, int n);
		send_word(CMD_PUSH_START, len, 8'($urandom), 10'($urandom));
		repeat (n)
			send_word(CMD_PUSH_DATA, 10'($urandom), 8'($urandom), 10'($urandom));
	endtask

	// change the mode once every result is back
	task automatic write_mode(bit m);
		in_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.overwrite_mode <= m;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [9:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 10'($urandom_range(12));
		if (r < 85)
			return 10'($urandom_range(135, 120));
		if (r < 97 || big_left == 0)
			return 10'($urandom_range(300));
		big_left--;
		return 10'($urandom_range(1022, 900));
	endfunction

	task automatic random_word();
		int r;
		logic [9:0] len;
		r = $urandom_range(99);
		if (r < 50) begin
			len = pick_len();
			// now and then leave a push unfinished
			push_record(len, ($urandom_range(19) == 0) ? $urandom_range(len) : len);
		end else if (r < 65)
			send_word(CMD_POP, 10'($urandom), 8'($urandom), 10'($urandom));
		else if (r < 82)
			send_word(CMD_READ, 10'($urandom), 8'($urandom),
				($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(15)));
		else
			send_word(cmd_t'($urandom_range(3)), 10'($urandom), 8'($urandom), 10'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_if.valid <= 1'b0;
		in_if.cmd <= CMD_POP;
		in_if.entry_length <= '0;
		in_if.data_byte <= '0;
		in_if.byte_index <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.overwrite_mode <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: refuse mode corner cases
		write_mode(1'b0);
		send_word(CMD_POP, 10'd0, 8'd0, 10'd0);
		send_word(CMD_READ, 10'd0, 8'd0, 10'd0);
		send_word(CMD_PUSH_DATA, 10'd0, 8'hff, 10'd0);
		send_word(CMD_PUSH_START, 10'd1023, 8'd0, 10'd0);
		send_word(CMD_PUSH_START, 10'd1022, 8'd0, 10'd0);
		push_record(10'd0, 0);
		send_word(CMD_READ, 10'd0, 8'd0, 10'd0);
		send_word(CMD_PUSH_START, 10'd1021, 8'd0, 10'd0);
		send_word(CMD_PUSH_START, 10'd3, 8'd0, 10'd0);
		send_word(CMD_PUSH_START, 10'd5, 8'd0, 10'd0);
		send_word(CMD_POP, 10'd0, 8'd0, 10'd0);
		send_word(CMD_PUSH_DATA, 10'd0, 8'h00, 10'd0);
		send_word(CMD_PUSH_DATA, 10'd0, 8'hff, 10'd0);
		send_word(CMD_PUSH_DATA, 10'd0, 8'ha5, 10'd0);
		send_word(CMD_READ, 10'd0, 8'd0, 10'd2);
		send_word(CMD_READ, 10'd0, 8'd0, 10'd3);
		send_word(CMD_READ, 10'd0, 8'd0, 10'd1023);
		send_word(CMD_POP, 10'd0, 8'd0, 10'd0);
		send_word(CMD_POP, 10'd0, 8'd0, 10'd0);

		// directed: overwrite drops old records
		write_mode(1'b1);
		push_record(10'd3, 3);
		push_record(10'd1021, 1021);
		send_word(CMD_READ, 10'd0, 8'd0, 10'd1020);

		// random phases across both modes, one without idling
		for (int ph = 0; ph < 6; ph++) begin
			int first;
			write_mode(ph == 1 || ph == 4 ? 1'b0 : 1'b1);
			idle_en = (ph != 2);
			first = word_cnt;
			while (word_cnt - first < 110)
				random_word();
		end
		idle_en = 1'b1;
		in_if.valid <= 1'b0;
		@(posedge clk);

		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
rtl/vper_pkg.sv
rtl/vper_if.sv
rtl/vper_ram.sv
rtl/varint_prefixed_entry_ring.sv
tb/sv/varint_ring_checker.sv
tb/sv/varint_prefixed_entry_ring_tb.sv
